>>> sv/bounded_linear_probe_slot_allocator_defines.svh
// Assertion helpers for the slot allocator.
`ifndef BOUNDED_LINEAR_PROBE_SLOT_ALLOCATOR_DEFINES_SVH
`define BOUNDED_LINEAR_PROBE_SLOT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define BLPSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BLPSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/blpsa_pkg.sv
`default_nettype none

package blpsa_pkg;

	localparam int unsigned SLOT_W         = 16;
	localparam int unsigned WORD_W         = 16;
	localparam int unsigned OFF_W          = 4;
	localparam int unsigned WIX_W          = SLOT_W - OFF_W;
	localparam int unsigned SLOT_COUNT_DEF = 65536;
	localparam int unsigned SLOT_SPACE     = 65536;

	localparam logic [15:0] PROBE_BUDGET_RST = 16'd8;
	localparam logic [15:0] HALF_TOP         = 16'h7fff;
	localparam logic [15:0] SLOT_TOP         = 16'hffff;
	localparam logic [15:0] SLOT_FIRST       = 16'd1;

	localparam logic ACT_INSERT  = 1'b0;
	localparam logic ACT_RELEASE = 1'b1;

	// One queued request: the slot is the normalized home for an insert,
	// the named slot for a release.
	typedef struct packed {
		logic        act;
		logic [15:0] slot;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [15:0] home_of(input logic [15:0] raw);
		logic [15:0] h;
		h = raw;
		if (raw == 16'd0) begin
			h = SLOT_FIRST;
		end else if (raw == SLOT_TOP) begin
			h = HALF_TOP;
		end
		return h;
	endfunction

endpackage

`default_nettype wire

>>> sv/bounded_linear_probe_slot_allocator.sv
// Bounded linear-probe slot allocator. Issue a request by raising start in a
// cycle where busy is low: action 0 inserts at home_slot (0 maps to 1, all-ones
// maps to 0x7fff), action 1 frees release_slot. Every request returns exactly
// one beat: done is high for one cycle with granted and slot, and the receiver
// cannot stall it, so capture the beat in the cycle it appears. In the back
// end a request passes a bitmap word read and then an evaluate and write;
// a release, or an insert whose free slot sits in the home word, finishes
// there, and each further 16-slot word the probe must cross adds another
// evaluate pass. An insert probes at most probe_budget+1 slots. A two-beat
// queue sits between the request front end and the back end, so start may
// be accepted while a request is still probing; after the sweep, busy rises
// only when that queue is full. After reset the block sweeps all
// ceil(min(SLOT_COUNT,65536)/16) bitmap words clear (4096 at the default
// size), one word a cycle, with busy high. probe_budget is written through
// the cfg channel, which is always ready; write it only while the block is
// idle.

`default_nettype none

`include "bounded_linear_probe_slot_allocator_defines.svh"

module bounded_linear_probe_slot_allocator #(
	parameter int unsigned SLOT_COUNT = blpsa_pkg::SLOT_COUNT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        action,
	input  wire logic [15:0] home_slot,
	input  wire logic [15:0] release_slot,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	output logic             done,
	output logic             granted,
	output logic [15:0]      slot
);

	logic               push;
	logic               pop;
	logic               clearing;
	blpsa_pkg::entry_t  push_entry;
	blpsa_pkg::entry_t  head;
	blpsa_pkg::q_stat_t q_stat;
	logic [15:0]        probe_budget_q;

	// Take the register write in any cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_budget_q <= blpsa_pkg::PROBE_BUDGET_RST;
		end else if (cfg_valid && cfg_ready) begin
			probe_budget_q <= cfg_data;
		end
	end

	// Front end: accept, normalize the home slot, queue the request.
	blpsa_front u_front (
		.start        (start),
		.action       (action),
		.home_slot    (home_slot),
		.release_slot (release_slot),
		.q_stat       (q_stat),
		.clearing     (clearing),
		.busy         (busy),
		.push         (push),
		.push_entry   (push_entry)
	);

	// Decouple front from back so each side stalls on its own.
	blpsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// Back end: word-wide probe over the occupancy memory, one beat per request.
	blpsa_back #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.probe_budget (probe_budget_q),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.clearing     (clearing),
		.done         (done),
		.granted      (granted),
		.slot         (slot)
	);

	// A request passes at least a read and an evaluate state in the back end.
	`BLPSA_ASSERT_NXT(a_done_spaced, clk, arst_n, done, !done, "result beats too close")
	// A failed insert reports slot zero.
	`BLPSA_ASSERT_IMP(a_fail_slot, clk, arst_n, done && !granted, slot == 16'd0, "failed insert slot")
	// The queue never takes a beat while full nor gives one while empty.
	`BLPSA_ASSERT_IMP(a_q_push, clk, arst_n, push, !q_stat.full, "queue overflow")
	`BLPSA_ASSERT_IMP(a_q_pop, clk, arst_n, pop, !q_stat.empty, "queue underflow")

endmodule

`default_nettype wire

>>> sv/blpsa_front.sv
`default_nettype none

module blpsa_front (
	input  wire logic               start,
	input  wire logic               action,
	input  wire logic [15:0]        home_slot,
	input  wire logic [15:0]        release_slot,
	input  wire blpsa_pkg::q_stat_t q_stat,
	input  wire logic               clearing,
	output logic                    busy,
	output logic                    push,
	output blpsa_pkg::entry_t       push_entry
);

	// Hold off new requests while the bitmap is swept or the queue is full.
	assign busy = clearing | q_stat.full;
	assign push = start & ~busy;

	always_comb begin
		push_entry.act = action;
		if (action == blpsa_pkg::ACT_RELEASE) begin
			push_entry.slot = release_slot;
		end else begin
			push_entry.slot = blpsa_pkg::home_of(home_slot);
		end
	end

endmodule

`default_nettype wire

>>> sv/blpsa_queue.sv
`default_nettype none

module blpsa_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire blpsa_pkg::entry_t push_entry,
	input  wire logic              pop,
	output blpsa_pkg::entry_t      head,
	output blpsa_pkg::q_stat_t     q_stat
);

	blpsa_pkg::entry_t ent_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;

	assign head         = ent_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/blpsa_back.sv
`default_nettype none

module blpsa_back #(
	parameter int unsigned SLOT_COUNT = blpsa_pkg::SLOT_COUNT_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [15:0]        probe_budget,
	input  wire blpsa_pkg::entry_t  head,
	input  wire blpsa_pkg::q_stat_t q_stat,
	output logic                    pop,
	output logic                    clearing,
	output logic                    done,
	output logic                    granted,
	output logic [15:0]             slot
);

	localparam int unsigned WORD_W = blpsa_pkg::WORD_W;
	localparam int unsigned OFF_W  = blpsa_pkg::OFF_W;
	localparam int unsigned WIX_W  = blpsa_pkg::WIX_W;
	localparam int unsigned EFF    = (SLOT_COUNT < blpsa_pkg::SLOT_SPACE) ?
	                                 SLOT_COUNT : blpsa_pkg::SLOT_SPACE;
	localparam int unsigned DEPTH  = (EFF + WORD_W - 1) / WORD_W;
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_READ  = 3'b010,
		ST_EVAL  = 3'b100
	} back_st_t;

	back_st_t           st_q;
	logic [15:0]        cand_q;
	logic               act_q;
	logic [15:0]        rem_q;
	logic [ADDR_W-1:0]  clr_q;
	logic               done_q;
	logic               granted_q;
	logic [15:0]        slot_q;

	logic [WORD_W-1:0]  mem_q [DEPTH];
	logic [WORD_W-1:0]  rd_data_q;

	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [WORD_W-1:0]  wr_data;

	logic [WIX_W-1:0]   wix;
	logic [OFF_W-1:0]   off;
	logic               in_range;
	logic               last;
	logic [WORD_W-1:0]  word;
	logic [WORD_W-1:0]  elig;
	logic               found;
	logic [OFF_W-1:0]   fb;
	logic [4:0]         cnt;
	logic               fail;
	logic [15:0]        next_cand;
	logic               rel_ok;
	logic [WIX_W-1:0]   head_wix;
	logic [WIX_W-1:0]   next_wix;

	assign clearing = (st_q == ST_CLEAR);
	assign done     = done_q;
	assign granted  = granted_q;
	assign slot     = slot_q;

	assign wix      = cand_q[15:OFF_W];
	assign off      = cand_q[OFF_W-1:0];
	assign in_range = 32'(wix) < DEPTH;
	assign last     = (wix == '1);
	assign word     = in_range ? rd_data_q : '1;
	assign rel_ok   = 32'(cand_q) < SLOT_COUNT;
	assign head_wix = head.slot[15:OFF_W];

	// Free bits the probe may still reach in the current word.
	always_comb begin
		logic [15:0] sv;
		logic [3:0]  gap;
		elig = '0;
		for (int b = 0; b < WORD_W; b++) begin
			sv      = {wix, OFF_W'(b)};
			gap     = OFF_W'(b) - off;
			elig[b] = (OFF_W'(b) >= off) && ({12'd0, gap} <= rem_q)
			          && !(last && (b == WORD_W - 1))
			          && (32'(sv) < SLOT_COUNT) && !word[b];
		end
	end

	always_comb begin
		fb = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (elig[b]) begin
				fb = OFF_W'(b);
			end
		end
	end

	assign found     = |elig;
	assign cnt       = last ? (5'd15 - {1'b0, off}) : (5'd16 - {1'b0, off});
	assign fail      = rem_q < {11'd0, cnt};
	assign next_wix  = wix + 1'b1;
	assign next_cand = last ? blpsa_pkg::SLOT_FIRST : {next_wix, {OFF_W{1'b0}}};

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = wix[ADDR_W-1:0];
		wr_data = '0;
		pop     = 1'b0;
		case (st_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			ST_READ: begin
				pop     = ~q_stat.empty;
				rd_en   = ~q_stat.empty && (32'(head_wix) < DEPTH);
				rd_addr = head_wix[ADDR_W-1:0];
			end
			ST_EVAL: begin
				if (act_q == blpsa_pkg::ACT_RELEASE) begin
					wr_en   = rel_ok;
					wr_data = word & ~(WORD_W'(1) << off);
				end else if (found) begin
					wr_en   = 1'b1;
					wr_data = word | (WORD_W'(1) << fb);
				end else if (!fail) begin
					rd_en   = 32'(next_cand[15:OFF_W]) < DEPTH;
					rd_addr = next_cand[ADDR_W+OFF_W-1:OFF_W];
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			clr_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						st_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (!q_stat.empty) begin
						st_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if ((act_q == blpsa_pkg::ACT_RELEASE) || found || fail) begin
						done_q <= 1'b1;
						st_q   <= ST_READ;
					end
				end
				default: begin
					st_q <= ST_READ;
				end
			endcase
		end
	end

	// Probe bookkeeping and result payload.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_READ: begin
				cand_q <= head.slot;
				act_q  <= head.act;
				rem_q  <= probe_budget;
			end
			ST_EVAL: begin
				if (act_q == blpsa_pkg::ACT_RELEASE) begin
					granted_q <= 1'b1;
					slot_q    <= cand_q;
				end else if (found) begin
					granted_q <= 1'b1;
					slot_q    <= {wix, fb};
				end else if (fail) begin
					granted_q <= 1'b0;
					slot_q    <= '0;
				end else begin
					rem_q  <= rem_q - {11'd0, cnt};
					cand_q <= next_cand;
				end
			end
			default: begin
				cand_q <= cand_q;
			end
		endcase
	end

endmodule

`default_nettype wire
